/* hdl/kabf_pkg.sv */
// Package for the two-state angle/bias Kalman filter.
// Holds field widths, register codes, reset values, unit request types
// and saturation helpers. No dependencies.
package kabf_pkg;

  localparam int ANG_W     = 32;  // angle, rate, bias: signed Q16.16
  localparam int COV_W     = 48;  // covariance: signed Q16.32
  localparam int DT_W      = 24;  // time step: unsigned Q0.24
  localparam int MEAS_W    = 25;
  localparam int GYRO_W    = 28;
  localparam int NOISE_W   = 32;  // noise variances: unsigned Q0.32
  localparam int GAIN_W    = 32;  // gain: signed Q1.30
  localparam int MRES_W    = 56;  // scaled product out of the multiplier
  localparam int SUM_W     = 58;  // headroom for sums before saturation
  localparam int CFG_IDX_W = 2;

  localparam logic [NOISE_W-1:0] Q_ANGLE_RST = 32'd4294967;
  localparam logic [NOISE_W-1:0] Q_BIAS_RST  = 32'd12884902;
  localparam logic [NOISE_W-1:0] R_MEAS_RST  = 32'd128849019;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Q_ANGLE = 2'd0,
    REG_Q_BIAS  = 2'd1,
    REG_R_MEAS  = 2'd2
  } cfg_reg_t;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_SET    = 1'b1;

  // shift select for the multiplier: floor(a*b / 2^24) or / 2^30
  localparam logic SH_24 = 1'b0;
  localparam logic SH_30 = 1'b1;

  typedef struct packed {
    logic                    start;
    logic                    sh30;
    logic signed [COV_W-1:0] a;
    logic signed [GAIN_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [MRES_W-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic                    start;
    logic signed [COV_W-1:0] num;
    logic [COV_W-1:0]        den;   // strictly positive
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [GAIN_W-1:0] q;
  } div_rsp_t;

  function automatic logic signed [ANG_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic ovf;
    ovf = !((&v[SUM_W-1:ANG_W-1]) || !(|v[SUM_W-1:ANG_W-1]));
    if (!ovf)
      return v[ANG_W-1:0];
    else if (v[SUM_W-1])
      return {1'b1, {(ANG_W-1){1'b0}}};
    else
      return {1'b0, {(ANG_W-1){1'b1}}};
  endfunction

  function automatic logic signed [COV_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic ovf;
    ovf = !((&v[SUM_W-1:COV_W-1]) || !(|v[SUM_W-1:COV_W-1]));
    if (!ovf)
      return v[COV_W-1:0];
    else if (v[SUM_W-1])
      return {1'b1, {(COV_W-1){1'b0}}};
    else
      return {1'b0, {(COV_W-1){1'b1}}};
  endfunction

endpackage

/* hdl/kabf_in_if.sv */
// Input channel of the angle/bias filter: valid/ready plus one item.
// Depends on kabf_pkg.
interface kabf_in_if;
  import kabf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [MEAS_W-1:0] measured_angle;
  logic signed [GYRO_W-1:0] gyro_rate;
  logic [DT_W-1:0]          time_step;

  modport source (output valid, command, measured_angle, gyro_rate, time_step,
                  input ready);
  modport sink   (input valid, command, measured_angle, gyro_rate, time_step,
                  output ready);
endinterface

/* hdl/kabf_out_if.sv */
// Result channel of the angle/bias filter: valid/ready plus one result.
// Depends on kabf_pkg.
interface kabf_out_if;
  import kabf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] filtered_angle;
  logic signed [ANG_W-1:0] unbiased_rate;
  logic signed [ANG_W-1:0] bias_estimate;

  modport source (output valid, filtered_angle, unbiased_rate, bias_estimate,
                  input ready);
  modport sink   (input valid, filtered_angle, unbiased_rate, bias_estimate,
                  output ready);
endinterface

/* hdl/kabf_mul.sv */
// Shared multiplier: floor(a*b / 2^n), n = 24 or 30, a 48-bit, b 32-bit signed.
// b is taken in two 16-bit digits, low then high. Depends on kabf_pkg.
module kabf_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  kabf_pkg::mul_req_t req,
  output kabf_pkg::mul_rsp_t rsp
);
  import kabf_pkg::*;

  localparam int PROD_W = COV_W + 17;
  localparam int ACC_W  = COV_W + GAIN_W;

  logic                     busy_r, busy_nxt;
  logic [1:0]               ph_r, ph_nxt;
  logic                     done_r, done_nxt;
  logic                     sh30_r, sh30_nxt;
  logic signed [COV_W-1:0]  a_r, a_nxt;
  logic signed [GAIN_W-1:0] b_r, b_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    sh30_nxt = sh30_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      ph_nxt   = 2'd0;
      sh30_nxt = req.sh30;
      a_nxt    = req.a;
      b_nxt    = req.b;
    end else if (busy_r) begin
      case (ph_r)
        2'd0: begin
          prod_nxt = a_r * $signed({1'b0, b_r[15:0]});
          ph_nxt   = 2'd1;
        end
        2'd1: begin
          acc_nxt  = ACC_W'(prod_r);
          prod_nxt = a_r * $signed(b_r[31:16]);
          ph_nxt   = 2'd2;
        end
        default: begin
          acc_nxt  = acc_r + (ACC_W'(prod_r) <<< 16);
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    sh30_r <= sh30_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = sh30_r ? MRES_W'($signed(acc_r[ACC_W-1:30]))
                           : $signed(acc_r[ACC_W-1:24]);

endmodule

/* hdl/kabf_div.sv */
// Gain divider: num / den in Q1.30, truncated toward zero, saturated.
// Restoring, one quotient bit per cycle. Depends on kabf_pkg.
module kabf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  kabf_pkg::div_req_t req,
  output kabf_pkg::div_rsp_t rsp
);
  import kabf_pkg::*;

  localparam int FRAC = 30;
  localparam int QW   = FRAC + 1;

  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_SETUP = 3'b010,
    D_ITER  = 3'b100
  } dstate_t;

  dstate_t          st_r, st_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [COV_W-1:0] mag_r, mag_nxt;
  logic [COV_W-1:0] d_r, d_nxt;
  logic [COV_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [COV_W:0]   rem2;

  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    rem2     = {rem_r, 1'b0};
    unique case (st_r)
      D_IDLE: begin
        if (req.start) begin
          neg_nxt = req.num[COV_W-1];
          mag_nxt = req.num[COV_W-1] ? COV_W'(-req.num) : COV_W'(req.num);
          d_nxt   = req.den;
          st_nxt  = D_SETUP;
        end
      end
      D_SETUP: begin
        if ({1'b0, mag_r} >= {d_r, 1'b0}) begin
          q_nxt    = '1;
          done_nxt = 1'b1;
          st_nxt   = D_IDLE;
        end else begin
          if (mag_r >= d_r) begin
            rem_nxt = mag_r - d_r;
            q_nxt   = QW'(1);
          end else begin
            rem_nxt = mag_r;
            q_nxt   = '0;
          end
          cnt_nxt = 5'(FRAC);
          st_nxt  = D_ITER;
        end
      end
      D_ITER: begin
        if (rem2 >= {1'b0, d_r}) begin
          rem_nxt = COV_W'(rem2 - {1'b0, d_r});
          q_nxt   = {q_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[COV_W-1:0];
          q_nxt   = {q_r[QW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          done_nxt = 1'b1;
          st_nxt   = D_IDLE;
        end
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

/* hdl/kalman_angle_bias_filter_core.sv */
// Two-state angle/gyro-bias Kalman filter, sequenced over a shared multiplier
// and an iterative gain divider. Set item: no products, straight to the output step.
// Update item: ten products, two gain divisions, then the output step; when the
// innovation variance is not positive, the four predict products and output step.
// One item at a time; input is ready again in the same cycle the result is raised.
// Synchronous active-low reset: noise registers to defaults, state to zero.
module kalman_angle_bias_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  kabf_in_if.sink                           in_ch,
  kabf_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [kabf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kabf_pkg::NOISE_W-1:0]      cfg_data
);
  import kabf_pkg::*;

  // sequencer
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MISSUE = 6'b000010,
    S_MWAIT  = 6'b000100,
    S_DISSUE = 6'b001000,
    S_DWAIT  = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  // product steps: predict first, then correction
  localparam logic [3:0] ST_ANG_PRED = 4'd0;  // angle += rate*dt
  localparam logic [3:0] ST_P11_DT   = 4'd1;  // pd = P11*dt
  localparam logic [3:0] ST_P00_PRED = 4'd2;  // P00 += t*dt, P01/P10 -= pd
  localparam logic [3:0] ST_P11_PRED = 4'd3;  // P11 += Qb*dt
  localparam logic [3:0] ST_ANG_CORR = 4'd4;  // angle += K0*y
  localparam logic [3:0] ST_BIAS_COR = 4'd5;  // bias  += K1*y
  localparam logic [3:0] ST_P10_CORR = 4'd6;  // P10 -= P00*K1
  localparam logic [3:0] ST_P11_CORR = 4'd7;  // P11 -= P01*K1
  localparam logic [3:0] ST_P00_CORR = 4'd8;  // P00 -= P00*K0
  localparam logic [3:0] ST_P01_CORR = 4'd9;  // P01 -= P01*K0

  state_t                   state_r, state_nxt;
  logic [3:0]               step_r, step_nxt;
  logic                     dsel_r, dsel_nxt;     // 0: K0, 1: K1

  logic [NOISE_W-1:0]       qa_r, qa_nxt, qb_r, qb_nxt, rm_r, rm_nxt;

  logic signed [ANG_W-1:0]  ang_r, ang_nxt, bias_r, bias_nxt;
  logic signed [COV_W-1:0]  p00_r, p00_nxt, p01_r, p01_nxt;
  logic signed [COV_W-1:0]  p10_r, p10_nxt, p11_r, p11_nxt;

  logic signed [ANG_W-1:0]  rate_r, rate_nxt;
  logic signed [MEAS_W-1:0] meas_r, meas_nxt;
  logic [DT_W-1:0]          dt_r, dt_nxt;
  logic signed [COV_W-1:0]  pd_r, pd_nxt;
  logic [COV_W-1:0]         s_r, s_nxt;
  logic signed [ANG_W-1:0]  y_r, y_nxt;
  logic signed [GAIN_W-1:0] k0_r, k0_nxt, k1_r, k1_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [ANG_W-1:0]  o_ang_r, o_ang_nxt, o_rate_r, o_rate_nxt;
  logic signed [ANG_W-1:0]  o_bias_r, o_bias_nxt;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  logic signed [SUM_W-1:0]  t_sum;
  logic signed [COV_W-1:0]  t_sat;
  logic signed [SUM_W-1:0]  mres;
  logic signed [COV_W:0]    s_sum;
  logic                     s_pos;
  logic                     in_xfer;
  logic [GAIN_W-1:0]        dt_ext;

  kabf_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  kabf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // t = P11*dt - P01 - P10 + Qa, from the pd register
  assign t_sum = SUM_W'(pd_r) - SUM_W'(p01_r) - SUM_W'(p10_r) + $signed(SUM_W'(qa_r));
  assign t_sat = sat48(t_sum);
  assign mres  = SUM_W'(mrsp.res);
  assign dt_ext = GAIN_W'(dt_r);

  // innovation variance after the predicted P00 is in place
  assign s_sum = (COV_W+1)'(p00_r) + $signed((COV_W+1)'(rm_r));
  assign s_pos = !s_sum[COV_W] && (s_sum != '0);

  // multiplier operands per step
  always_comb begin
    mreq.start = (state_r == S_MISSUE);
    mreq.sh30  = SH_30;
    mreq.a     = '0;
    mreq.b     = '0;
    case (step_r)
      ST_ANG_PRED: begin
        mreq.sh30 = SH_24; mreq.a = COV_W'(rate_r); mreq.b = $signed(dt_ext);
      end
      ST_P11_DT: begin
        mreq.sh30 = SH_24; mreq.a = p11_r; mreq.b = $signed(dt_ext);
      end
      ST_P00_PRED: begin
        mreq.sh30 = SH_24; mreq.a = t_sat; mreq.b = $signed(dt_ext);
      end
      ST_P11_PRED: begin
        mreq.sh30 = SH_24; mreq.a = $signed(COV_W'(qb_r)); mreq.b = $signed(dt_ext);
      end
      ST_ANG_CORR: begin mreq.a = COV_W'(y_r); mreq.b = k0_r; end
      ST_BIAS_COR: begin mreq.a = COV_W'(y_r); mreq.b = k1_r; end
      ST_P10_CORR: begin mreq.a = p00_r;       mreq.b = k1_r; end
      ST_P11_CORR: begin mreq.a = p01_r;       mreq.b = k1_r; end
      ST_P00_CORR: begin mreq.a = p00_r;       mreq.b = k0_r; end
      ST_P01_CORR: begin mreq.a = p01_r;       mreq.b = k0_r; end
      default: ;
    endcase
  end

  always_comb begin
    dreq.start = (state_r == S_DISSUE);
    dreq.num   = dsel_r ? p10_r : p00_r;
    dreq.den   = s_r;
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    dsel_nxt      = dsel_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    rm_nxt        = rm_r;
    ang_nxt       = ang_r;
    bias_nxt      = bias_r;
    p00_nxt       = p00_r;
    p01_nxt       = p01_r;
    p10_nxt       = p10_r;
    p11_nxt       = p11_r;
    rate_nxt      = rate_r;
    meas_nxt      = meas_r;
    dt_nxt        = dt_r;
    pd_nxt        = pd_r;
    s_nxt         = s_r;
    y_nxt         = y_r;
    k0_nxt        = k0_r;
    k1_nxt        = k1_r;
    o_ang_nxt     = o_ang_r;
    o_rate_nxt    = o_rate_r;
    o_bias_nxt    = o_bias_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_Q_ANGLE: qa_nxt = cfg_data;
        REG_Q_BIAS:  qb_nxt = cfg_data;
        REG_R_MEAS:  rm_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          meas_nxt = in_ch.measured_angle;
          dt_nxt   = in_ch.time_step;
          // unbiased rate uses the bias from before the item, both commands
          rate_nxt = sat32(SUM_W'(in_ch.gyro_rate) - SUM_W'(bias_r));
          if (in_ch.command == CMD_SET) begin
            ang_nxt   = ANG_W'(in_ch.measured_angle);
            bias_nxt  = '0;
            p00_nxt   = '0;
            p01_nxt   = '0;
            p10_nxt   = '0;
            p11_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            step_nxt  = ST_ANG_PRED;
            state_nxt = S_MISSUE;
          end
        end
      end
      S_MISSUE: state_nxt = S_MWAIT;
      S_MWAIT: begin
        if (mrsp.done) begin
          state_nxt = S_MISSUE;
          step_nxt  = step_r + 4'd1;
          case (step_r)
            ST_ANG_PRED: ang_nxt = sat32(SUM_W'(ang_r) + mres);
            ST_P11_DT:   pd_nxt  = COV_W'(mrsp.res);
            ST_P00_PRED: begin
              p00_nxt = sat48(SUM_W'(p00_r) + mres);
              p01_nxt = sat48(SUM_W'(p01_r) - SUM_W'(pd_r));
              p10_nxt = sat48(SUM_W'(p10_r) - SUM_W'(pd_r));
            end
            ST_P11_PRED: begin
              p11_nxt  = sat48(SUM_W'(p11_r) + mres);
              s_nxt    = s_sum[COV_W-1:0];
              y_nxt    = sat32(SUM_W'(meas_r) - SUM_W'(ang_r));
              dsel_nxt = 1'b0;
              // no correction when the innovation variance is not positive
              state_nxt = s_pos ? S_DISSUE : S_OUT;
            end
            ST_ANG_CORR: ang_nxt  = sat32(SUM_W'(ang_r) + mres);
            ST_BIAS_COR: bias_nxt = sat32(SUM_W'(bias_r) + mres);
            ST_P10_CORR: p10_nxt  = sat48(SUM_W'(p10_r) - mres);
            ST_P11_CORR: p11_nxt  = sat48(SUM_W'(p11_r) - mres);
            ST_P00_CORR: p00_nxt  = sat48(SUM_W'(p00_r) - mres);
            ST_P01_CORR: begin
              p01_nxt   = sat48(SUM_W'(p01_r) - mres);
              state_nxt = S_OUT;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_DISSUE: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (drsp.done) begin
          if (!dsel_r) begin
            k0_nxt    = drsp.q;
            dsel_nxt  = 1'b1;
            state_nxt = S_DISSUE;
          end else begin
            k1_nxt    = drsp.q;
            step_nxt  = ST_ANG_CORR;
            state_nxt = S_MISSUE;
          end
        end
      end
      S_OUT: begin
        // load the result register once the previous result is taken
        if (!out_valid_r || out_ch.ready) begin
          o_ang_nxt     = ang_r;
          o_rate_nxt    = rate_r;
          o_bias_nxt    = bias_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_ANG_PRED;
      dsel_r      <= 1'b0;
      out_valid_r <= 1'b0;
      qa_r        <= Q_ANGLE_RST;
      qb_r        <= Q_BIAS_RST;
      rm_r        <= R_MEAS_RST;
      ang_r       <= '0;
      bias_r      <= '0;
      p00_r       <= '0;
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      dsel_r      <= dsel_nxt;
      out_valid_r <= out_valid_nxt;
      qa_r        <= qa_nxt;
      qb_r        <= qb_nxt;
      rm_r        <= rm_nxt;
      ang_r       <= ang_nxt;
      bias_r      <= bias_nxt;
      p00_r       <= p00_nxt;
      p01_r       <= p01_nxt;
      p10_r       <= p10_nxt;
      p11_r       <= p11_nxt;
    end
    rate_r   <= rate_nxt;
    meas_r   <= meas_nxt;
    dt_r     <= dt_nxt;
    pd_r     <= pd_nxt;
    s_r      <= s_nxt;
    y_r      <= y_nxt;
    k0_r     <= k0_nxt;
    k1_r     <= k1_nxt;
    o_ang_r  <= o_ang_nxt;
    o_rate_r <= o_rate_nxt;
    o_bias_r <= o_bias_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_angle = o_ang_r;
  assign out_ch.unbiased_rate  = o_rate_r;
  assign out_ch.bias_estimate  = o_bias_r;

  // checks
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mreq.start && dreq.start))
    else $error("multiplier and divider started together");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input ready right after a transfer");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> state_r == S_MWAIT)
    else $error("product finished while sequencer not waiting");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == S_DWAIT)
    else $error("gain finished while sequencer not waiting");

endmodule
